[hdl/ccae_pkg.sv]
// shared types and constants for the color code to ansi expander
// holds the queue command type and the escape sequence table
// no dependencies

package ccae_pkg;

  // input byte that arms a pending color code
  localparam logic [7:0] CTRL_C = 8'h03;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // longest escape sequence and the width of a byte index into it
  localparam int unsigned SEQ_MAX = 11;
  localparam int unsigned SEQ_IDX_W = $clog2(SEQ_MAX);

  // number of sequences: reset plus nine colors
  localparam int unsigned SEQ_COUNT = 10;
  localparam int unsigned SEQ_SEL_W = $clog2(SEQ_COUNT);

  // command handed from front to back
  typedef struct packed {
    logic       expand;  // 1: data is a color code byte, 0: pass data through
    logic [7:0] data;
  } cmd_t;

  // escape sequence bytes, row 0 is the reset sequence, rows 1 to 9 the colors
  localparam logic [7:0] SEQ_TABLE [SEQ_COUNT][SEQ_MAX] = '{
    '{8'h1b, 8'h5b, 8'h30, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h33, 8'h36, 8'h6d, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h33, 8'h33, 8'h6d, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h35, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h34, 8'h34, 8'h6d, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h32, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h35, 8'h3b, 8'h33, 8'h31, 8'h6d},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h33, 8'h34, 8'h6d, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h34, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h36, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // index of the last byte of each sequence
  localparam logic [SEQ_IDX_W-1:0] SEQ_LAST_IDX [SEQ_COUNT] = '{
    SEQ_IDX_W'(3), SEQ_IDX_W'(8), SEQ_IDX_W'(8), SEQ_IDX_W'(6), SEQ_IDX_W'(8),
    SEQ_IDX_W'(6), SEQ_IDX_W'(10), SEQ_IDX_W'(8), SEQ_IDX_W'(6), SEQ_IDX_W'(6)
  };

endpackage

[hdl/ccae_front.sv]
// front end: accepts input bytes, tracks the pending color code flag
// and turns each byte into a queue command or nothing; uses ccae_pkg

module ccae_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output ccae_pkg::cmd_t  push_cmd
);

  logic ansi_enable;
  logic code_pending;
  logic code_pending_next;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ansi_enable <= 1'b1;
    end else if (cfg_we) begin
      ansi_enable <= cfg_wdata;
    end
  end

  // classify the byte of an accepted transaction
  always_comb begin
    code_pending_next = code_pending;
    push              = 1'b0;
    push_cmd.expand   = code_pending;
    push_cmd.data     = in_byte;
    if (accept) begin
      if (in_byte == ccae_pkg::CTRL_C) begin
        code_pending_next = 1'b1;
      end else if (!code_pending) begin
        push = 1'b1;
      end else begin
        code_pending_next = 1'b0;
        push              = ansi_enable;
      end
    end
  end

  // pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      code_pending <= 1'b0;
    end else begin
      code_pending <= code_pending_next;
    end
  end

endmodule

[hdl/ccae_queue.sv]
// short command queue between front and back
// register array with head and tail pointers; uses ccae_pkg

module ccae_queue #(
  parameter int unsigned DEPTH = ccae_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ccae_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output ccae_pkg::cmd_t  head_cmd
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ccae_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/ccae_back.sv]
// back end: takes commands from the queue and emits output bytes,
// walking the escape sequence table for color codes; uses ccae_pkg

module ccae_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ccae_pkg::cmd_t  head_cmd,
  output logic            pop,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_last,
  input  logic            out_ready
);

  logic [ccae_pkg::SEQ_IDX_W-1:0] idx;
  logic [ccae_pkg::SEQ_SEL_W-1:0] sel;
  logic [7:0]                     byte_now;
  logic                           last_now;
  logic                           load;

  // sequence select: digits one to nine pick a color, anything else reset
  always_comb begin
    if (head_cmd.data inside {[8'h31:8'h39]}) begin
      sel = head_cmd.data[ccae_pkg::SEQ_SEL_W-1:0];
    end else begin
      sel = '0;
    end
  end

  // byte and end marker for the current command
  always_comb begin
    if (head_cmd.expand) begin
      byte_now = ccae_pkg::SEQ_TABLE[sel][idx];
      last_now = (idx == ccae_pkg::SEQ_LAST_IDX[sel]);
    end else begin
      byte_now = head_cmd.data;
      last_now = 1'b1;
    end
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last_now;

  // byte index within the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last_now ? '0 : idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_now;
      out_last <= last_now;
    end
  end

endmodule

[hdl/color_code_to_ansi_expander_unit.sv]
// top level of the color code to ansi expander
// instantiates ccae_front, ccae_queue and ccae_back; uses ccae_pkg
//
// usage:
// - input stream s_axis: one terminal byte per transaction in s_axis_tdata
// - output stream m_axis: one byte per transaction, m_axis_tlast marks the
//   final byte produced by one input byte
// - cfg_we/cfg_wdata write ansi_enable (reset 1); write only while idle
// - a ctrl-c byte produces nothing and arms a pending code; the next other
//   byte becomes an escape sequence of 4 to 11 bytes (or nothing when
//   ansi_enable is 0); other bytes pass through unchanged
// - throughput: one output byte per cycle from the back end while
//   m_axis_tready is high; pass-through bytes flow at one per cycle, a color
//   code holds the back end until every byte of its sequence is out
// - a 4-entry command queue decouples input from output; s_axis_tready drops
//   when it is full, so a stalled receiver backs up into the input
// - reset clears the pending code, the queue and the output register and
//   sets ansi_enable to 1

module color_code_to_ansi_expander_unit #(
  parameter int unsigned QUEUE_DEPTH = ccae_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,       // ansi_enable
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic           push;
  ccae_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  ccae_pkg::cmd_t head_cmd;

  // input classification
  ccae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_byte  (s_axis_tdata),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  ccae_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // output expansion
  ccae_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_ready (m_axis_tready)
  );

endmodule

[test/color_code_to_ansi_expander_unit_test.sv]
// self-checking testbench for color_code_to_ansi_expander_unit
// drives terminal bytes and compares output bytes against an in-bench expander model
// depends on ccae_pkg and the rtl under hdl

`timescale 1ns / 1ps

module color_code_to_ansi_expander_unit_test;

  localparam logic [7:0] ESC_CHAR = 8'h1b;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 100;

  // directed plan row kinds: echoed byte, no output, modeled output, enable write
  typedef enum logic [1:0] {
    ROW_ECHO,
    ROW_SILENT,
    ROW_PREDICT,
    ROW_CFG
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t kind;
    logic [7:0] value;  // input byte, or ansi_enable in bit 0 for ROW_CFG
  } plan_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  localparam int unsigned PLAN_LEN = 24;
  localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
    '{ROW_ECHO, 8'h00},
    '{ROW_ECHO, 8'hff},
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_PREDICT, "1"},
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_SILENT, ccae_pkg::CTRL_C},      // repeated ctrl-c keeps the code armed
    '{ROW_PREDICT, "6"},                  // longest sequence
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_PREDICT, "0"},                  // reset sequence
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_PREDICT, 8'hff},                // unknown code byte
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_PREDICT, "9"},
    '{ROW_CFG, 8'h00},
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_SILENT, "5"},                   // expansion disabled drops the code
    '{ROW_ECHO, 8'h7f},
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_SILENT, "0"},
    '{ROW_CFG, 8'h01},
    '{ROW_SILENT, ccae_pkg::CTRL_C},
    '{ROW_PREDICT, "3"},
    '{ROW_ECHO, 8'h20}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;

  // expander model state and expected output bytes
  logic      code_armed = 1'b0;
  logic      ansi_on = 1'b1;
  out_beat_t expected_out [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned expansions = 0;
  int unsigned codes_dropped = 0;

  color_code_to_ansi_expander_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
             expected_out.size());
    $display("color_code_to_ansi_expander_unit_test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // escape sequence text after the leading esc, per color selector
  function automatic string color_body(input int unsigned sel);
    case (sel)
      1: return "[0;1;36m";
      2: return "[0;1;33m";
      3: return "[0;35m";
      4: return "[0;1;44m";
      5: return "[0;32m";
      6: return "[0;1;5;31m";
      7: return "[0;1;34m";
      8: return "[0;34m";
      9: return "[0;36m";
      default: return "[0m";
    endcase
  endfunction

  // advance the expander model by one input byte, queue its output if asked
  task automatic expand_byte(input logic [7:0] b, input bit keep);
    string       body;
    int unsigned sel;
    out_beat_t   beat;
    if (b == ccae_pkg::CTRL_C) begin
      code_armed = 1'b1;
    end else if (!code_armed) begin
      beat.data = b;
      beat.last = 1'b1;
      if (keep) expected_out.push_back(beat);
    end else if (!ansi_on) begin
      code_armed = 1'b0;
      codes_dropped++;
    end else begin
      code_armed = 1'b0;
      expansions++;
      sel = (b >= "1" && b <= "9") ? int'(b) - int'("0") : 0;
      body = color_body(sel);
      if (keep) begin
        beat.data = ESC_CHAR;
        beat.last = 1'b0;
        expected_out.push_back(beat);
        for (int k = 0; k < body.len(); k++) begin
          beat.data = body[k];
          beat.last = (k == body.len() - 1);
          expected_out.push_back(beat);
        end
      end
    end
  endtask

  // offer one byte on the input stream, idling first as the phase asks
  task automatic send_byte(input logic [7:0] b, input bit keep);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    expand_byte(b, keep);
  endtask

  // hold the input until every expected byte is out, optionally settle after
  task automatic drain_outputs(input bit settle);
    if (settle || expected_out.size() != 0) s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ansi_enable(input logic v);
    drain_outputs(1'b1);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ansi_on = v;
  endtask

  // output side: check each transaction, then stall at random
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata, want.data));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b on byte %h", m_axis_tlast,
                                    want.last, want.data));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int unsigned phase_enable [4];
    int unsigned phase_send [4];
    int unsigned phase_recv [4];
    int unsigned sent;
    logic [7:0]  code;
    phase_enable = '{1, 0, 1, 1};
    phase_send = '{0, 84, 0, 23};
    phase_recv = '{0, 0, 84, 23};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed plan, ansi_enable still at its reset value
    foreach (DIRECTED_PLAN[i]) begin
      case (DIRECTED_PLAN[i].kind)
        ROW_CFG: begin
          write_ansi_enable(DIRECTED_PLAN[i].value[0]);
        end
        ROW_ECHO: begin
          send_byte(DIRECTED_PLAN[i].value, 1'b0);
          expected_out.push_back(out_beat_t'{DIRECTED_PLAN[i].value, 1'b1});
        end
        ROW_SILENT: begin
          send_byte(DIRECTED_PLAN[i].value, 1'b0);
        end
        default: begin
          send_byte(DIRECTED_PLAN[i].value, 1'b1);
        end
      endcase
    end

    // random phases, each with its own enable and idling mix
    for (int p = 0; p < 4; p++) begin
      write_ansi_enable(phase_enable[p][0]);
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 3) begin
          // hold off until the output has fully caught up
          drain_outputs(1'b0);
        end
        if ($urandom_range(99) < 45) begin
          // color code: ctrl-c, sometimes repeated, then a code byte
          send_byte(ccae_pkg::CTRL_C, 1'b1);
          sent++;
          if ($urandom_range(9) == 0) begin
            send_byte(ccae_pkg::CTRL_C, 1'b1);
            sent++;
          end
          if ($urandom_range(9) < 8) code = 8'("0") + 8'($urandom_range(9));
          else code = 8'($urandom_range(255));
          send_byte(code, 1'b1);
          sent++;
        end else begin
          send_byte(8'($urandom_range(255)), 1'b1);
          sent++;
        end
      end
    end

    drain_outputs(1'b1);
    $display("sent %0d bytes and checked %0d output bytes in four idling mixes",
             bytes_sent, beats_seen);
    $display("%0d color codes expanded, %0d dropped with expansion disabled",
             expansions, codes_dropped);
    if (error_count == 0) begin
      $display("color_code_to_ansi_expander_unit_test passed");
    end else begin
      $display("color_code_to_ansi_expander_unit_test failed");
    end
    $finish;
  end

endmodule
